// ===== rtl/dcp_pkg.sv =====
// dcp_pkg: shared widths, command and opcode types, and the control/status
// structs passed between the dag_critical_path controller and datapath.
// No dependencies.
package dcp_pkg;

  localparam int CMD_W        = 2;
  localparam int NODE_W       = 10;
  localparam int DUR_IN_W     = 16;
  localparam int FIN_W        = 26;
  localparam int CNT_W        = 11;
  localparam int IN_TDATA_W   = 40;
  localparam int OUT_TDATA_W  = 32;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;

  localparam int DEF_MAX_NODES     = 1024;
  localparam int DEF_MAX_EDGES     = 4096;
  localparam int DEF_DURATION_BITS = 16;

  localparam logic [APB_ADDR_W-1:0] CFG_NODE_COUNT = 3'd0;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_DUR  = 2'd0,
    CMD_ADD_EDGE = 2'd1,
    CMD_RUN      = 2'd2
  } cmd_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_SET_DUR,
    OP_ADD_EDGE,
    OP_START,
    OP_CLR,
    OP_CNT_RD,
    OP_CNT_CHK,
    OP_CNT_WR,
    OP_SEED_RD,
    OP_SEED_WR,
    OP_POP_RD,
    OP_POP_FIN,
    OP_POP_LATCH,
    OP_REL_RD,
    OP_REL_CHK,
    OP_REL_WR,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e  op;
    logic idx_clear;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic idx_at_n;
    logic idx_at_edges;
    logic queue_empty;
  } dp_stat_t;

endpackage

// ===== rtl/dcp_ctrl.sv =====
// dcp_ctrl: sequencer for load and run requests; steps the datapath through
// clear, in-degree count, seeding and relaxation. Depends on dcp_pkg.
module dcp_ctrl
  import dcp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] in_cmd_i,
  output logic             in_ready_o,
  input  logic             out_free_i,
  input  dp_stat_t         stat_i,
  output dp_cmd_t          cmd_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CLR       = 4'd1;
  localparam logic [3:0] S_CNT_RD    = 4'd2;
  localparam logic [3:0] S_CNT_CHK   = 4'd3;
  localparam logic [3:0] S_CNT_WR    = 4'd4;
  localparam logic [3:0] S_SEED_RD   = 4'd5;
  localparam logic [3:0] S_SEED_WR   = 4'd6;
  localparam logic [3:0] S_POP_RD    = 4'd7;
  localparam logic [3:0] S_POP_FIN   = 4'd8;
  localparam logic [3:0] S_POP_LATCH = 4'd9;
  localparam logic [3:0] S_REL_RD    = 4'd10;
  localparam logic [3:0] S_REL_CHK   = 4'd11;
  localparam logic [3:0] S_REL_WR    = 4'd12;
  localparam logic [3:0] S_DONE      = 4'd13;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.op      = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_cmd_i)
            CMD_SET_DUR:  cmd_o.op = OP_SET_DUR;
            CMD_ADD_EDGE: cmd_o.op = OP_ADD_EDGE;
            CMD_RUN: begin
              cmd_o.op        = OP_START;
              cmd_o.idx_clear = 1'b1;
              state_d         = S_CLR;
            end
            default: cmd_o.op = OP_NONE;
          endcase
        end
      end
      S_CLR: begin
        if (stat_i.idx_at_n) begin
          cmd_o.idx_clear = 1'b1;
          state_d         = S_CNT_RD;
        end else begin
          cmd_o.op = OP_CLR;
        end
      end
      S_CNT_RD: begin
        if (stat_i.idx_at_edges) begin
          cmd_o.idx_clear = 1'b1;
          state_d         = S_SEED_RD;
        end else begin
          cmd_o.op = OP_CNT_RD;
          state_d  = S_CNT_CHK;
        end
      end
      S_CNT_CHK: begin
        cmd_o.op = OP_CNT_CHK;
        state_d  = S_CNT_WR;
      end
      S_CNT_WR: begin
        cmd_o.op = OP_CNT_WR;
        state_d  = S_CNT_RD;
      end
      S_SEED_RD: begin
        if (stat_i.idx_at_n) begin
          state_d = S_POP_RD;
        end else begin
          cmd_o.op = OP_SEED_RD;
          state_d  = S_SEED_WR;
        end
      end
      S_SEED_WR: begin
        cmd_o.op = OP_SEED_WR;
        state_d  = S_SEED_RD;
      end
      S_POP_RD: begin
        if (stat_i.queue_empty) begin
          state_d = S_DONE;
        end else begin
          cmd_o.op = OP_POP_RD;
          state_d  = S_POP_FIN;
        end
      end
      S_POP_FIN: begin
        cmd_o.op = OP_POP_FIN;
        state_d  = S_POP_LATCH;
      end
      S_POP_LATCH: begin
        cmd_o.op        = OP_POP_LATCH;
        cmd_o.idx_clear = 1'b1;
        state_d         = S_REL_RD;
      end
      S_REL_RD: begin
        if (stat_i.idx_at_edges) begin
          state_d = S_POP_RD;
        end else begin
          cmd_o.op = OP_REL_RD;
          state_d  = S_REL_CHK;
        end
      end
      S_REL_CHK: begin
        cmd_o.op = OP_REL_CHK;
        state_d  = S_REL_WR;
      end
      S_REL_WR: begin
        cmd_o.op = OP_REL_WR;
        state_d  = S_REL_RD;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (out_free_i) begin
          cmd_o.op       = OP_FINISH;
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/dcp_datapath.sv =====
// dcp_datapath: node and edge memories, ready queue, counters and the
// finish-time adder/compare. Driven by dcp_ctrl commands; depends on dcp_pkg.
module dcp_datapath
  import dcp_pkg::*;
#(
  parameter int MAX_NODES     = DEF_MAX_NODES,
  parameter int MAX_EDGES     = DEF_MAX_EDGES,
  parameter int DURATION_BITS = DEF_DURATION_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  input  logic [CNT_W-1:0]    node_count_i,
  input  logic [NODE_W-1:0]   node_a_i,
  input  logic [NODE_W-1:0]   node_b_i,
  input  logic [DUR_IN_W-1:0] duration_i,
  output dp_stat_t            stat_o,
  output logic [FIN_W-1:0]    makespan_o,
  output logic                dropped_o
);

  localparam int NA_W  = $clog2(MAX_NODES);
  localparam int N_W   = $clog2(MAX_NODES + 1);
  localparam int EA_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int E_W   = $clog2(MAX_EDGES + 1);
  localparam int IDX_W = (N_W > E_W) ? N_W : E_W;
  localparam int NV_W  = (NODE_W > NA_W) ? NODE_W : NA_W;
  localparam int FT_W  = (DURATION_BITS > FIN_W) ? DURATION_BITS : FIN_W;
  localparam int SUM_W = FT_W + 1;
  localparam logic [FT_W-1:0] FIN_MAX = FT_W'({FIN_W{1'b1}});

  // memories
  logic [DURATION_BITS-1:0] dur_mem  [MAX_NODES];
  logic [NV_W-1:0]          src_mem  [MAX_EDGES];
  logic [NV_W-1:0]          tgt_mem  [MAX_EDGES];
  logic [E_W-1:0]           pend_mem [MAX_NODES];
  logic [FT_W-1:0]          fin_mem  [MAX_NODES];
  logic [NA_W-1:0]          q_mem    [MAX_NODES];

  logic [DURATION_BITS-1:0] dur_rd_q;
  logic [NV_W-1:0]          src_rd_q, tgt_rd_q;
  logic [E_W-1:0]           pend_rd_q;
  logic [FT_W-1:0]          fin_rd_q;
  logic [NA_W-1:0]          q_rd_q;

  // control registers
  logic [IDX_W-1:0] idx_q;
  logic [N_W-1:0]   head_q, tail_q;
  logic [E_W-1:0]   edge_total_q;
  logic             overflow_q;
  logic [FT_W-1:0]  best_q;
  logic [NA_W-1:0]  cur_q;
  logic [FT_W-1:0]  curfin_q;

  logic [N_W-1:0]   n_act;
  logic [NA_W-1:0]  node_idx, tgt_node;
  logic [EA_W-1:0]  edge_idx, edge_wa;
  logic             edge_ok, rel_hit, a_ok, edge_room, push_ok;
  logic [DURATION_BITS-1:0] dur_wr;
  logic [SUM_W-1:0] cand_sum;
  logic [FT_W-1:0]  cand, new_fin, seed_fin;

  logic                 dur_we, dur_re, edge_we, edge_re;
  logic                 pend_we, pend_re, fin_we, fin_re, q_we, q_re;
  logic [NA_W-1:0]      dur_ra, pend_wa, pend_ra, fin_wa, fin_ra, q_wa;
  logic [E_W-1:0]       pend_wd;
  logic [FT_W-1:0]      fin_wd;
  logic [NA_W-1:0]      q_wd;
  logic                 push, idx_inc;

  always_comb begin
    if (node_count_i == '0) begin
      n_act = N_W'(1);
    end else if (32'(node_count_i) > MAX_NODES) begin
      n_act = N_W'(MAX_NODES);
    end else begin
      n_act = N_W'(node_count_i);
    end
  end

  assign node_idx  = idx_q[NA_W-1:0];
  assign edge_idx  = idx_q[EA_W-1:0];
  assign edge_wa   = edge_total_q[EA_W-1:0];
  assign tgt_node  = tgt_rd_q[NA_W-1:0];
  assign edge_ok   = (32'(src_rd_q) < 32'(n_act)) && (32'(tgt_rd_q) < 32'(n_act));
  assign rel_hit   = (src_rd_q == NV_W'(cur_q)) && (32'(tgt_rd_q) < 32'(n_act));
  assign a_ok      = 32'(node_a_i) < MAX_NODES;
  assign edge_room = 32'(edge_total_q) < MAX_EDGES;
  assign push_ok   = 32'(tail_q) < MAX_NODES;
  assign dur_wr    = DURATION_BITS'(32'(duration_i));

  // relaxation: saturate predecessor finish plus own duration
  assign cand_sum = SUM_W'(curfin_q) + SUM_W'(dur_rd_q);
  assign cand     = (cand_sum > SUM_W'(FIN_MAX)) ? FIN_MAX : cand_sum[FT_W-1:0];
  assign new_fin  = (cand > fin_rd_q) ? cand : fin_rd_q;
  assign seed_fin = FT_W'(dur_rd_q);

  always_comb begin
    dur_we  = 1'b0;
    dur_re  = 1'b0;
    dur_ra  = node_idx;
    edge_we = 1'b0;
    edge_re = 1'b0;
    pend_we = 1'b0;
    pend_wa = node_idx;
    pend_wd = '0;
    pend_re = 1'b0;
    pend_ra = node_idx;
    fin_we  = 1'b0;
    fin_wa  = node_idx;
    fin_wd  = '0;
    fin_re  = 1'b0;
    fin_ra  = tgt_node;
    q_we    = 1'b0;
    q_wa    = tail_q[NA_W-1:0];
    q_wd    = node_idx;
    q_re    = 1'b0;
    push    = 1'b0;
    idx_inc = 1'b0;
    unique case (cmd_i.op)
      OP_SET_DUR:  dur_we  = a_ok;
      OP_ADD_EDGE: edge_we = edge_room;
      OP_CLR: begin
        pend_we = 1'b1;
        fin_we  = 1'b1;
        idx_inc = 1'b1;
      end
      OP_CNT_RD: edge_re = 1'b1;
      OP_CNT_CHK: begin
        pend_re = 1'b1;
        pend_ra = tgt_node;
      end
      OP_CNT_WR: begin
        pend_we = edge_ok;
        pend_wa = tgt_node;
        pend_wd = pend_rd_q + E_W'(1);
        idx_inc = 1'b1;
      end
      OP_SEED_RD: begin
        pend_re = 1'b1;
        dur_re  = 1'b1;
      end
      OP_SEED_WR: begin
        fin_we  = (pend_rd_q == '0);
        fin_wd  = seed_fin;
        push    = (pend_rd_q == '0) && push_ok;
        idx_inc = 1'b1;
      end
      OP_POP_RD:  q_re = 1'b1;
      OP_POP_FIN: begin
        fin_re = 1'b1;
        fin_ra = q_rd_q;
      end
      OP_REL_RD: edge_re = 1'b1;
      OP_REL_CHK: begin
        pend_re = 1'b1;
        pend_ra = tgt_node;
        dur_re  = 1'b1;
        dur_ra  = tgt_node;
        fin_re  = 1'b1;
      end
      OP_REL_WR: begin
        pend_we = rel_hit && (pend_rd_q != '0);
        pend_wa = tgt_node;
        pend_wd = pend_rd_q - E_W'(1);
        fin_we  = rel_hit;
        fin_wa  = tgt_node;
        fin_wd  = new_fin;
        q_wd    = tgt_node;
        push    = rel_hit && (pend_rd_q == E_W'(1)) && push_ok;
        idx_inc = 1'b1;
      end
      default: ;
    endcase
    q_we = push;
  end

  always_ff @(posedge clk_i) begin
    if (dur_we) dur_mem[NA_W'(node_a_i)] <= dur_wr;
    if (dur_re) dur_rd_q <= dur_mem[dur_ra];
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      src_mem[edge_wa] <= NV_W'(node_a_i);
      tgt_mem[edge_wa] <= NV_W'(node_b_i);
    end
    if (edge_re) begin
      src_rd_q <= src_mem[edge_idx];
      tgt_rd_q <= tgt_mem[edge_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_we) pend_mem[pend_wa] <= pend_wd;
    if (pend_re) pend_rd_q <= pend_mem[pend_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fin_we) fin_mem[fin_wa] <= fin_wd;
    if (fin_re) fin_rd_q <= fin_mem[fin_ra];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    if (q_re) q_rd_q <= q_mem[head_q[NA_W-1:0]];
  end

  // payload latches for the node being expanded
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_POP_FIN) cur_q <= q_rd_q;
    if (cmd_i.op == OP_POP_LATCH) curfin_q <= fin_rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q        <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      edge_total_q <= '0;
      overflow_q   <= 1'b0;
      best_q       <= '0;
    end else begin
      if (cmd_i.idx_clear) begin
        idx_q <= '0;
      end else if (idx_inc) begin
        idx_q <= idx_q + IDX_W'(1);
      end
      if (cmd_i.op == OP_START) begin
        head_q <= '0;
        tail_q <= '0;
        best_q <= '0;
      end else begin
        if (q_re) head_q <= head_q + N_W'(1);
        if (push) tail_q <= tail_q + N_W'(1);
        if (fin_we && (cmd_i.op != OP_CLR) && (fin_wd > best_q)) best_q <= fin_wd;
      end
      if (cmd_i.op == OP_ADD_EDGE) begin
        if (edge_room) begin
          edge_total_q <= edge_total_q + E_W'(1);
        end else begin
          overflow_q <= 1'b1;
        end
      end else if (cmd_i.op == OP_FINISH) begin
        edge_total_q <= '0;
        overflow_q   <= 1'b0;
      end
    end
  end

  assign stat_o.idx_at_n     = (32'(idx_q) == 32'(n_act));
  assign stat_o.idx_at_edges = (32'(idx_q) == 32'(edge_total_q));
  assign stat_o.queue_empty  = (head_q == tail_q);
  assign makespan_o          = best_q[FIN_W-1:0];
  assign dropped_o           = overflow_q;

endmodule

// ===== rtl/dag_critical_path.sv =====
// dag_critical_path: critical path length of a task graph by Kahn order.
// Load items (set duration, add edge) are taken one per cycle while no run is
// in progress. A run walks the node and edge memories through clear, in-degree
// count, seeding and, per popped node, a relaxation pass over every edge; the
// result then waits in an output register. Reset clears control state only;
// pending counts and finish times are cleared by a pass over the n nodes in use
// at the start of every run.
module dag_critical_path
  import dcp_pkg::*;
#(
  parameter int MAX_NODES     = DEF_MAX_NODES,
  parameter int MAX_EDGES     = DEF_MAX_EDGES,
  parameter int DURATION_BITS = DEF_DURATION_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // node_a, node_b, duration, zero pad
  input  logic [CMD_W-1:0]       s_axis_tuser,  // command
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // makespan, edges_dropped, zero pad
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  logic [CNT_W-1:0] node_count_q;
  logic             out_valid_q;
  logic [FIN_W-1:0] out_span_q;
  logic             out_drop_q;
  logic [FIN_W-1:0] makespan;
  logic             dropped;
  logic             out_free;

  assign pready = 1'b1;
  assign prdata = (paddr == CFG_NODE_COUNT) ? APB_DATA_W'(node_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CNT_W'(1);
    end else if (psel && penable && pwrite && pready && (paddr == CFG_NODE_COUNT)) begin
      node_count_q <= pwdata[CNT_W-1:0];
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  dcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  dcp_datapath #(
    .MAX_NODES     (MAX_NODES),
    .MAX_EDGES     (MAX_EDGES),
    .DURATION_BITS (DURATION_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .node_count_i (node_count_q),
    .node_a_i     (s_axis_tdata[9:0]),
    .node_b_i     (s_axis_tdata[19:10]),
    .duration_i   (s_axis_tdata[35:20]),
    .stat_o       (dp_stat),
    .makespan_o   (makespan),
    .dropped_o    (dropped)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (dp_cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd.out_load) begin
      out_span_q <= makespan;
      out_drop_q <= dropped;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - FIN_W - 1){1'b0}}, out_drop_q, out_span_q};

`ifndef SYNTH
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.out_load |-> (!out_valid_q || m_axis_tready))
    else $error("result loaded over an untaken result");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.out_load |=> m_axis_tvalid)
    else $error("loaded result not presented");

  a_run_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_RUN)) |=> !s_axis_tready)
    else $error("input still open after run request");
`endif

endmodule

// ===== tb/sv/dag_critical_path_tb.sv =====
// Testbench for dag_critical_path: streams duration, edge and run requests,
// checks each makespan and drop flag against an in-bench longest-path model.
// Depends on dcp_pkg and the dag_critical_path RTL.
module dag_critical_path_tb;
  import dcp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    cmd_e             cmd;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [15:0]      duration;
  } req_t;

  typedef struct {
    logic [FIN_W-1:0] makespan;
    logic             edges_dropped;
  } span_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [CMD_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr = '0;
  logic [APB_DATA_W-1:0]  pwdata = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  dag_critical_path dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0]       dur_mem [1024];
  logic [NODE_W-1:0] edge_src [4096];
  logic [NODE_W-1:0] edge_dst [4096];
  int                edge_cnt = 0;
  bit                edge_ovf = 1'b0;
  logic [CNT_W-1:0]  node_cnt = 11'd1;

  req_t  pending_reqs [$];
  span_t spans_due [$];
  req_t  cur_req;
  bit    taken = 1'b0;
  int    errors = 0;
  int    cycle_no = 0;
  bit    calm;

  function automatic logic [FIN_W-1:0] longest_path();
    int     n, head, tail, cur, t;
    longint best, cand;
    int     indeg [1024];
    longint fin [1024];
    int     order [1024];
    n = (node_cnt == 0) ? 1 : ((node_cnt > 1024) ? 1024 : int'(node_cnt));
    head = 0;
    tail = 0;
    best = 0;
    for (int i = 0; i < 1024; i++) begin
      indeg[i] = 0;
      fin[i] = 0;
    end
    for (int e = 0; e < edge_cnt; e++)
      if (edge_src[e] < n && edge_dst[e] < n) indeg[edge_dst[e]]++;
    for (int i = 0; i < n; i++)
      if (indeg[i] == 0) begin
        order[tail++] = i;
        fin[i] = dur_mem[i];
        if (fin[i] > best) best = fin[i];
      end
    while (head < tail) begin
      cur = order[head++];
      for (int e = 0; e < edge_cnt; e++) begin
        if (edge_src[e] != cur || edge_dst[e] >= n) continue;
        t = edge_dst[e];
        if (indeg[t] > 0) begin
          indeg[t]--;
          if (indeg[t] == 0 && tail < 1024) order[tail++] = t;
        end
        cand = fin[cur] + dur_mem[t];
        if (cand > 64'h3FFFFFF) cand = 64'h3FFFFFF;
        if (cand > fin[t]) fin[t] = cand;
        if (fin[t] > best) best = fin[t];
      end
    end
    return best[FIN_W-1:0];
  endfunction

  function automatic void apply_req(req_t r);
    span_t s;
    case (r.cmd)
      CMD_SET_DUR: dur_mem[r.node_a] = r.duration;
      CMD_ADD_EDGE: begin
        if (edge_cnt < 4096) begin
          edge_src[edge_cnt] = r.node_a;
          edge_dst[edge_cnt] = r.node_b;
          edge_cnt++;
        end else edge_ovf = 1'b1;
      end
      CMD_RUN: begin
        s.makespan = longest_path();
        s.edges_dropped = edge_ovf;
        spans_due.insert(spans_due.size(), s);
        edge_cnt = 0;
        edge_ovf = 1'b0;
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
    if (s_axis_tvalid && s_axis_tready) begin
      apply_req(cur_req);
      taken = 1'b1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (spans_due.size() == 0) begin
        $error("unexpected result: makespan %0d", m_axis_tdata[FIN_W-1:0]);
        errors++;
      end else begin
        span_t s;
        s = spans_due.pop_front();
        if (m_axis_tdata[FIN_W-1:0] !== s.makespan) begin
          $error("makespan: expected %0d, actual %0d", s.makespan, m_axis_tdata[FIN_W-1:0]);
          errors++;
        end
        if (m_axis_tdata[FIN_W] !== s.edges_dropped) begin
          $error("edges_dropped: expected %0d, actual %0d", s.edges_dropped,
                 m_axis_tdata[FIN_W]);
          errors++;
        end
      end
    end
  end

  assign calm = (cycle_no % 40000) < 6000;

  // driver: hold the request until taken, then advance or idle
  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 26);
      if (!s_axis_tvalid || taken) begin
        taken = 1'b0;
        if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 26)) begin
          cur_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_req.cmd;
          s_axis_tdata  <= {4'd0, cur_req.duration, cur_req.node_b, cur_req.node_a};
        end else begin
          s_axis_tvalid <= 1'b0;
          s_axis_tdata  <= IN_TDATA_W'({$urandom, $urandom});
        end
      end
    end
  end

  task automatic put(cmd_e c, int a, int b, int d);
    req_t r;
    r.cmd = c;
    r.node_a = NODE_W'(a);
    r.node_b = NODE_W'(b);
    r.duration = 16'(d);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic write_node_count(int value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= CFG_NODE_COUNT;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    node_cnt = value[CNT_W-1:0];
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !s_axis_tvalid && spans_due.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic int pick_dur();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 16'hFFFF;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // random graph on n nodes: forward edges mostly, some back edges and strays
  task automatic random_graph(int n, int edges);
    int a, b;
    for (int i = 0; i < edges; i++) begin
      case ($urandom_range(0, 9))
        0: put(CMD_SET_DUR, $urandom_range(0, n - 1), $urandom_range(0, 1023), pick_dur());
        1: put(cmd_e'(2'd3), $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
        2: put(CMD_ADD_EDGE, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
        3: put(CMD_ADD_EDGE, $urandom_range(0, n - 1), $urandom_range(0, n - 1), $urandom);
        default: begin
          a = $urandom_range(0, n - 1);
          b = (a == n - 1) ? a : $urandom_range(a + 1, n - 1);
          put(CMD_ADD_EDGE, a, b, $urandom);
        end
      endcase
    end
    put(CMD_RUN, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
  endtask

  initial begin
    int n, sent;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // define every duration so no run reads an unwritten node
    for (int i = 0; i < 1024; i++) put(CMD_SET_DUR, i, $urandom_range(0, 1023), pick_dur());
    put(CMD_RUN, 0, 0, 0);  // empty graph, one node
    drain();
    write_node_count(4);
    put(CMD_SET_DUR, 0, 0, 16'hFFFF);
    put(CMD_SET_DUR, 3, 1023, 0);
    put(CMD_ADD_EDGE, 0, 1, 0);
    put(CMD_ADD_EDGE, 1, 2, 0);
    put(CMD_ADD_EDGE, 2, 3, 0);
    put(CMD_ADD_EDGE, 0, 3, 0);
    put(CMD_ADD_EDGE, 1023, 1, 0);  // endpoint outside node count
    put(cmd_e'(2'd3), 1023, 1023, 16'hFFFF);
    put(CMD_RUN, 1023, 1023, 16'hFFFF);
    put(CMD_ADD_EDGE, 1, 2, 0);  // cycle between 1 and 2
    put(CMD_ADD_EDGE, 2, 1, 0);
    put(CMD_ADD_EDGE, 0, 1, 0);
    put(CMD_RUN, 0, 0, 0);
    drain();
    write_node_count(0);
    put(CMD_RUN, 0, 0, 0);
    drain();
    write_node_count(2047);
    random_graph(1024, 4);
    drain();
    write_node_count(1024);
    put(CMD_ADD_EDGE, 1022, 1023, 0);
    put(CMD_ADD_EDGE, 0, 1023, 0);
    put(CMD_RUN, 0, 0, 0);
    drain();
    sent = 0;
    while (sent < 500) begin
      case ($urandom_range(0, 9))
        0: n = $urandom_range(17, 1024);
        1: n = 1;
        default: n = $urandom_range(2, 16);
      endcase
      write_node_count(n);
      random_graph(n, (n > 16) ? $urandom_range(1, 4) : $urandom_range(4, 30));
      sent += pending_reqs.size();
      drain();
    end
    repeat (200) @(posedge clk_i);
    if (errors == 0 && spans_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
